[rtl/plts_pkg.sv]
// Shared types, widths and constants of the polyline turn angle statistics unit.
package plts_pkg;

  localparam int SEG_MAX   = 1024;
  localparam int IDX_W     = $clog2(SEG_MAX);
  localparam int CNT_W     = IDX_W + 1;
  localparam int COORD_W   = 24;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int DOT_W     = PROD_W + 1;
  localparam int CX_W      = DOT_W + 1;
  localparam int ANG_W     = 25;
  localparam int TURN_W    = 16;
  localparam int SUM_W     = 26;
  localparam int KIND_W    = 3;
  localparam int TOL_W     = 8;
  localparam int STEPS     = 20;
  localparam int STEP_W    = 5;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW   = $clog2(FIFO_DEPTH);
  localparam int IN_DATA_W  = 4 * COORD_W;
  localparam int OUT_DATA_W = 112;

  localparam logic signed [ANG_W-1:0] DEG90_Q16  = 25'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180_Q16 = 25'sd11796480;
  localparam logic [TURN_W-1:0]       TURN_MAX   = 16'd46080;

  typedef struct packed {
    logic signed [DIFF_W-1:0] ux;
    logic signed [DIFF_W-1:0] uz;
    logic signed [DIFF_W-1:0] vx;
    logic signed [DIFF_W-1:0] vz;
    logic                     joined;
    logic                     zero_vec;
    logic [KIND_W-1:0]        kind;
    logic [KIND_W-1:0]        prev_kind;
    logic [CNT_W-1:0]         seg_idx;
    logic                     last;
  } seg_entry_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [FIFO_AW:0] count;
  } fifo_status_t;

  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] a;
    case (i)
      5'd0:  a = 25'sd2949120;
      5'd1:  a = 25'sd1740967;
      5'd2:  a = 25'sd919879;
      5'd3:  a = 25'sd466945;
      5'd4:  a = 25'sd234379;
      5'd5:  a = 25'sd117304;
      5'd6:  a = 25'sd58666;
      5'd7:  a = 25'sd29335;
      5'd8:  a = 25'sd14668;
      5'd9:  a = 25'sd7334;
      5'd10: a = 25'sd3667;
      5'd11: a = 25'sd1833;
      5'd12: a = 25'sd917;
      5'd13: a = 25'sd458;
      5'd14: a = 25'sd229;
      5'd15: a = 25'sd115;
      5'd16: a = 25'sd57;
      5'd17: a = 25'sd29;
      5'd18: a = 25'sd14;
      5'd19: a = 25'sd7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[rtl/plts_front.sv]
// Front end: accepts segments, checks the junction and forms the turn vectors.
module plts_front import plts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [TOL_W-1:0]     cfg_wr_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [KIND_W-1:0]    in_tuser,
  input  logic                 in_tlast,
  input  fifo_status_t         fifo_st,
  output logic                 push,
  output seg_entry_t           push_data
);

  logic [TOL_W-1:0] tol_r;
  logic signed [COORD_W-1:0] psx_r, psz_r, pex_r, pez_r;
  logic [KIND_W-1:0] pkind_r;
  logic have_prev_r;
  logic [CNT_W-1:0] seg_idx_r, seg_idx_nxt;

  logic signed [COORD_W-1:0] sx, sz, ex, ez;
  logic signed [DIFF_W-1:0] djx, djz;
  logic [DIFF_W-1:0] mjx, mjz;
  logic near;

  assign sx = in_tdata[COORD_W-1:0];
  assign sz = in_tdata[2*COORD_W-1:COORD_W];
  assign ex = in_tdata[3*COORD_W-1:2*COORD_W];
  assign ez = in_tdata[4*COORD_W-1:3*COORD_W];

  assign in_tready = !fifo_st.full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    djx  = DIFF_W'(sx) - DIFF_W'(pex_r);
    djz  = DIFF_W'(sz) - DIFF_W'(pez_r);
    mjx  = djx[DIFF_W-1] ? DIFF_W'(-djx) : DIFF_W'(djx);
    mjz  = djz[DIFF_W-1] ? DIFF_W'(-djz) : DIFF_W'(djz);
    near = (mjx <= DIFF_W'(tol_r)) && (mjz <= DIFF_W'(tol_r));
    push_data.ux        = DIFF_W'(sx) - DIFF_W'(psx_r);
    push_data.uz        = DIFF_W'(sz) - DIFF_W'(psz_r);
    push_data.vx        = DIFF_W'(ex) - DIFF_W'(sx);
    push_data.vz        = DIFF_W'(ez) - DIFF_W'(sz);
    push_data.joined    = have_prev_r && near;
    push_data.zero_vec  = (push_data.ux == '0 && push_data.uz == '0) ||
                          (push_data.vx == '0 && push_data.vz == '0);
    push_data.kind      = in_tuser;
    push_data.prev_kind = pkind_r;
    push_data.seg_idx   = seg_idx_r;
    push_data.last      = in_tlast;
    seg_idx_nxt = (seg_idx_r < CNT_W'(SEG_MAX)) ? seg_idx_r + 1'b1 : seg_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= '0;
      have_prev_r <= 1'b0;
      seg_idx_r   <= '0;
      pkind_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
      if (push) begin
        if (in_tlast) begin
          have_prev_r <= 1'b0;
          seg_idx_r   <= '0;
          pkind_r     <= '0;
        end else begin
          have_prev_r <= 1'b1;
          seg_idx_r   <= seg_idx_nxt;
          pkind_r     <= in_tuser;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      psx_r <= sx;
      psz_r <= sz;
      pex_r <= ex;
      pez_r <= ez;
    end
  end

endmodule

[rtl/plts_fifo.sv]
// Short queue of classified segments between front and back end.
module plts_fifo import plts_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  seg_entry_t   push_data,
  input  logic         pop,
  output seg_entry_t   pop_data,
  output fifo_status_t st
);

  seg_entry_t mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  assign st.full   = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign st.empty  = (count_r == '0);
  assign st.count  = count_r;
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/plts_back.sv]
// Back end: turn angle by shared multiplier and CORDIC, statistics, mean divider.
module plts_back import plts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fifo_empty,
  input  seg_entry_t            pop_data,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_CORD  = 7'b0000100,
    ST_ROUND = 7'b0001000,
    ST_UPD   = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  seg_entry_t ent_r;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [DOT_W-1:0] dot_r, dot_nxt, cross_r, cross_nxt, cross_fin;
  logic [CX_W-1:0] x_r, x_nxt;
  logic signed [CX_W-1:0] y_r, y_nxt;
  logic [CX_W-1:0] ay;
  logic signed [ANG_W-1:0] z_r, z_nxt, zc;
  logic [TURN_W-1:0] d_r, d_nxt;
  logic [ANG_W-1:0] rnd;
  logic signed [DIFF_W-1:0] mul_a, mul_b;

  logic [TURN_W-1:0] best_r, best_nxt, chg_r, chg_nxt;
  logic [IDX_W-1:0]  bidx_r, bidx_nxt, joins_r, joins_nxt;
  logic [KIND_W-1:0] kb_r, kb_nxt, ka_r, ka_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  segcnt_r, segcnt_nxt;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [IDX_W:0]    shifted;
  logic [TURN_W-1:0] mean;
  logic [OUT_DATA_W-1:0] out_r, out_nxt;

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = out_r;
  assign pop        = (state_r == ST_IDLE) && !fifo_empty;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    prod_nxt   = prod_r;
    dot_nxt    = dot_r;
    cross_nxt  = cross_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    z_nxt      = z_r;
    d_nxt      = d_r;
    best_nxt   = best_r;
    chg_nxt    = chg_r;
    bidx_nxt   = bidx_r;
    joins_nxt  = joins_r;
    kb_nxt     = kb_r;
    ka_nxt     = ka_r;
    sum_nxt    = sum_r;
    segcnt_nxt = segcnt_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    out_nxt    = out_r;
    mean       = '0;
    cross_fin  = cross_r - DOT_W'(prod_r);
    ay         = y_r[CX_W-1] ? CX_W'(-y_r) : CX_W'(y_r);
    zc         = '0;
    rnd        = '0;
    shifted    = {rem_r, quo_r[SUM_W-1]};
    case (cnt_r[1:0])
      2'd0: begin mul_a = ent_r.ux; mul_b = ent_r.vx; end
      2'd1: begin mul_a = ent_r.uz; mul_b = ent_r.vz; end
      2'd2: begin mul_a = ent_r.ux; mul_b = ent_r.vz; end
      default: begin mul_a = ent_r.uz; mul_b = ent_r.vx; end
    endcase

    case (state_r)
      ST_IDLE: begin
        if (!fifo_empty) begin
          state_nxt = ST_MUL;
          cnt_nxt   = '0;
        end
      end
      ST_MUL: begin
        prod_nxt = PROD_W'(mul_a * mul_b);
        cnt_nxt  = cnt_r + 1'b1;
        case (cnt_r)
          5'd1: dot_nxt   = DOT_W'(prod_r);
          5'd2: dot_nxt   = dot_r + DOT_W'(prod_r);
          5'd3: cross_nxt = DOT_W'(prod_r);
          5'd4: begin
            x_nxt     = dot_r[DOT_W-1] ? CX_W'(-dot_r) : CX_W'(dot_r);
            y_nxt     = cross_fin[DOT_W-1] ? -CX_W'(cross_fin) : CX_W'(cross_fin);
            z_nxt     = '0;
            cnt_nxt   = '0;
            state_nxt = ST_CORD;
          end
          default: ;
        endcase
      end
      ST_CORD: begin
        x_nxt = x_r + (ay >> cnt_r);
        if (!y_r[CX_W-1]) begin
          y_nxt = y_r - $signed(x_r >> cnt_r);
          z_nxt = z_r + atan_q16(cnt_r);
        end else begin
          y_nxt = y_r + $signed(x_r >> cnt_r);
          z_nxt = z_r - atan_q16(cnt_r);
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(STEPS - 1)) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (z_r[ANG_W-1]) begin
          zc = '0;
        end else if (z_r > DEG90_Q16) begin
          zc = DEG90_Q16;
        end else begin
          zc = z_r;
        end
        if (dot_r[DOT_W-1]) begin
          zc = DEG180_Q16 - zc;
        end
        rnd = (ANG_W'(zc) + ANG_W'(128)) >> 8;
        if (ent_r.zero_vec) begin
          d_nxt = '0;
        end else if (rnd > ANG_W'(TURN_MAX)) begin
          d_nxt = TURN_MAX;
        end else begin
          d_nxt = TURN_W'(rnd);
        end
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (ent_r.joined) begin
          if (joins_r < IDX_W'(SEG_MAX - 1)) begin
            joins_nxt = joins_r + 1'b1;
            sum_nxt   = sum_r + SUM_W'(d_r);
          end
          if (d_r > best_r) begin
            best_nxt = d_r;
            bidx_nxt = (ent_r.seg_idx < CNT_W'(SEG_MAX - 1)) ?
                       IDX_W'(ent_r.seg_idx) : IDX_W'(SEG_MAX - 1);
            kb_nxt   = ent_r.prev_kind;
            ka_nxt   = ent_r.kind;
          end
          if (ent_r.prev_kind != ent_r.kind && d_r > chg_r) begin
            chg_nxt = d_r;
          end
        end
        if (ent_r.last) begin
          segcnt_nxt = (ent_r.seg_idx < CNT_W'(SEG_MAX)) ?
                       ent_r.seg_idx + 1'b1 : ent_r.seg_idx;
          rem_nxt    = '0;
          quo_nxt    = sum_nxt + SUM_W'(joins_nxt >> 1);
          cnt_nxt    = '0;
          state_nxt  = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (shifted >= {1'b0, joins_r}) begin
          rem_nxt = IDX_W'(shifted - {1'b0, joins_r});
          quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = IDX_W'(shifted);
          quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(SUM_W - 1)) begin
          if (joins_r == '0) begin
            mean = '0;
          end else if (quo_nxt > SUM_W'(TURN_MAX)) begin
            mean = TURN_MAX;
          end else begin
            mean = TURN_W'(quo_nxt);
          end
          out_nxt   = {1'b0, mean, sum_r, segcnt_r, joins_r, chg_r, ka_r, kb_r,
                       bidx_r, best_r};
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          best_nxt  = '0;
          chg_nxt   = '0;
          bidx_nxt  = '0;
          joins_nxt = '0;
          kb_nxt    = '0;
          ka_nxt    = '0;
          sum_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      best_r  <= '0;
      chg_r   <= '0;
      bidx_r  <= '0;
      joins_r <= '0;
      kb_r    <= '0;
      ka_r    <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      best_r  <= best_nxt;
      chg_r   <= chg_nxt;
      bidx_r  <= bidx_nxt;
      joins_r <= joins_nxt;
      kb_r    <= kb_nxt;
      ka_r    <= ka_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= pop_data;
    end
    prod_r   <= prod_nxt;
    dot_r    <= dot_nxt;
    cross_r  <= cross_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    d_r      <= d_nxt;
    segcnt_r <= segcnt_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    out_r    <= out_nxt;
  end

endmodule

[rtl/polyline_turn_angle_stats_unit.sv]
// Top level of the polyline turn angle statistics unit.
// Input channel in_*: one segment per item; tlast marks the final segment of a
// chain, tuser carries the segment kind. Output channel out_*: one statistics
// item per chain, sent after the item with tlast. cfg_wr_en/cfg_wr_data write
// the join tolerance; the user must do it only while the unit is idle (not checked).
// A front end checks the junction and forms the vectors, then queues the item
// in a four-entry queue. The back end takes each item through its shared
// multiplier, twenty CORDIC steps, rounding and the statistics update, and
// the last item of a chain adds a restoring divider for the mean before the
// result shows on out_tdata.
// The back end takes a new item only when it is done with the last one; up to
// four items are taken at full speed while the back end works.
// Reset (rst_n low at a clock edge) clears the chain, the queue and the
// tolerance. When the receiver holds out_tready low the result waits in its
// output register and the back end stops; the front end keeps accepting
// until the queue is full.
module polyline_turn_angle_stats_unit import plts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [TOL_W-1:0]      cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // start_x[23:0], start_z[47:24], end_x[71:48], end_z[95:72]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // segment_kind[2:0]
  input  logic [KIND_W-1:0]     in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // worst_turn[15:0], worst_index[25:16], worst_kind_before[28:26],
  // worst_kind_after[31:29], worst_change_turn[47:32], junction_count[57:48],
  // segment_count[68:58], turn_sum[94:69], mean_turn[110:95], zero[111]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  fifo_status_t fifo_st;
  seg_entry_t   push_data, pop_data;
  logic         push, pop;

  plts_front u_front (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .fifo_st, .push, .push_data
  );

  plts_fifo u_fifo (
    .clk, .rst_n, .push, .push_data, .pop, .pop_data, .st(fifo_st)
  );

  plts_back u_back (
    .clk, .rst_n, .fifo_empty(fifo_st.empty), .pop_data, .pop,
    .out_tvalid, .out_tready, .out_tdata
  );

`ifndef NO_ASSERTIONS
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_st.count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_st.full |-> !in_tready)
    else $error("item accepted into a full queue");

  a_change_le_worst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:32] <= out_tdata[15:0])
    else $error("kind change turn above worst turn");

  a_mean_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[110:95] <= TURN_MAX &&
                    {1'b0, out_tdata[57:48]} <= out_tdata[68:58]))
    else $error("mean or junction count out of range");
`endif

endmodule
